/* sv/c_string_literal_escaper_assert.svh */
// Assertion macros of the escaper, used by the back part.
`ifndef C_STRING_LITERAL_ESCAPER_ASSERT_SVH
`define C_STRING_LITERAL_ESCAPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("escaper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("escaper assertion failed");

`endif

/* sv/cle_pkg.sv */
// Types, character constants and helper functions of the string literal escaper.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

	// Character codes used in the literal text.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] NO_ESCAPE = 8'h00;

	// Reset value of the line length register.
	localparam logic [7:0] MAX_LINE_RESET = 8'd100;

	// Slots of the fixed output template; a job enables a subset of them.
	localparam int unsigned NUM_SLOTS   = 10;
	localparam int unsigned SLOT_OPEN   = 0;
	localparam int unsigned SLOT_BSLASH = 1;
	localparam int unsigned SLOT_CHAR   = 2;
	localparam int unsigned SLOT_NL_Q1  = 3;
	localparam int unsigned SLOT_NL_LF  = 4;
	localparam int unsigned SLOT_NL_Q2  = 5;
	localparam int unsigned SLOT_BRK_Q1 = 6;
	localparam int unsigned SLOT_BRK_LF = 7;
	localparam int unsigned SLOT_BRK_Q2 = 8;
	localparam int unsigned SLOT_CLOSE  = 9;

	// One classified input word: which template slots to send and the variable character.
	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [7:0]           chr;
	} job_t;

	// Escape letter of a byte, or NO_ESCAPE when it is sent as itself.
	function automatic logic [7:0] escape_letter(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			8'h00:   r = CH_ZERO;
			8'h07:   r = 8'h61;
			8'h08:   r = 8'h62;
			8'h0C:   r = 8'h66;
			8'h0A:   r = CH_N;
			8'h0D:   r = 8'h72;
			8'h09:   r = 8'h74;
			8'h0B:   r = 8'h76;
			8'h3F:   r = 8'h3F;
			8'h27:   r = 8'h27;
			8'h22:   r = 8'h22;
			8'h5C:   r = 8'h5C;
			default: r = NO_ESCAPE;
		endcase
		return r;
	endfunction

	// Byte of the template slot selected by a one-hot vector.
	function automatic logic [7:0] slot_byte(input logic [NUM_SLOTS-1:0] oh,
		input logic [7:0] chr);
		logic quote;
		logic lf;
		quote = oh[SLOT_OPEN] | oh[SLOT_NL_Q1] | oh[SLOT_NL_Q2] | oh[SLOT_BRK_Q1]
			| oh[SLOT_BRK_Q2] | oh[SLOT_CLOSE];
		lf = oh[SLOT_NL_LF] | oh[SLOT_BRK_LF];
		return ({8{quote}} & CH_QUOTE) | ({8{lf}} & CH_LF)
			| ({8{oh[SLOT_BSLASH]}} & CH_BSLASH) | ({8{oh[SLOT_CHAR]}} & chr);
	endfunction

endpackage

`default_nettype wire

/* sv/cle_queue.sv */
// Small first-word-fall-through queue of jobs between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module cle_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  cle_pkg::job_t     push_job,
	output logic              full,
	input  wire logic         pop,
	output logic              pop_valid,
	output cle_pkg::job_t     pop_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cle_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Storage is written at the write pointer only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/cle_front.sv */
// Front part: accepts input words, keeps the lookahead state and classifies each word into a job.
`timescale 1ns / 1ps
`default_nettype none

module cle_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        in_mode,
	input  wire logic [7:0]  in_data,
	output logic             push,
	output cle_pkg::job_t    push_job,
	input  wire logic        q_full
);

	logic [7:0] max_line_q;
	logic       started_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;
	logic [7:0] line_count_q;

	logic       next_data;
	logic       held_nl;
	logic       split_nl;
	logic [7:0] esc;
	logic [7:0] count_after;
	logic       brk;
	logic [7:0] count_next;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Classify the held byte against the incoming word.
	always_comb begin
		next_data   = !in_mode;
		held_nl     = (held_byte_q == cle_pkg::CH_LF);
		split_nl    = held_nl && next_data;
		esc         = cle_pkg::escape_letter(held_byte_q);
		count_after = split_nl ? 8'd0 : line_count_q + 8'd1;
		brk         = held_valid_q && (count_after == max_line_q)
			&& !(next_data && in_data == cle_pkg::CH_LF);
		count_next  = brk ? 8'd0 : count_after;
	end

	// Build the slot mask of the job.
	always_comb begin
		push_job      = '0;
		push_job.chr  = (esc != cle_pkg::NO_ESCAPE) ? esc : held_byte_q;
		push_job.mask[cle_pkg::SLOT_OPEN]   = !started_q;
		push_job.mask[cle_pkg::SLOT_BSLASH] = held_valid_q && (esc != cle_pkg::NO_ESCAPE);
		push_job.mask[cle_pkg::SLOT_CHAR]   = held_valid_q;
		push_job.mask[cle_pkg::SLOT_NL_Q1]  = held_valid_q && split_nl;
		push_job.mask[cle_pkg::SLOT_NL_LF]  = held_valid_q && split_nl;
		push_job.mask[cle_pkg::SLOT_NL_Q2]  = held_valid_q && split_nl;
		push_job.mask[cle_pkg::SLOT_BRK_Q1] = brk;
		push_job.mask[cle_pkg::SLOT_BRK_LF] = brk;
		push_job.mask[cle_pkg::SLOT_BRK_Q2] = brk;
		push_job.mask[cle_pkg::SLOT_CLOSE]  = in_mode;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q <= cle_pkg::MAX_LINE_RESET;
		end else if (cfg_wr_en) begin
			max_line_q <= cfg_wr_data;
		end
	end

	// Literal state: an end word resets it, a data word becomes the held byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			held_valid_q <= 1'b0;
			held_byte_q  <= 8'd0;
			line_count_q <= 8'd0;
		end else if (push) begin
			started_q <= !in_mode;
			if (in_mode) begin
				held_valid_q <= 1'b0;
				held_byte_q  <= 8'd0;
				line_count_q <= 8'd0;
			end else begin
				held_valid_q <= 1'b1;
				held_byte_q  <= in_data;
				if (held_valid_q) begin
					line_count_q <= count_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/cle_back.sv */
// Back part: walks each job's slot mask and sends one literal byte per cycle while the sink is ready.
`timescale 1ns / 1ps
`default_nettype none

`include "c_string_literal_escaper_assert.svh"

module cle_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  cle_pkg::job_t    q_job,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic [cle_pkg::NUM_SLOTS-1:0] mask_q;
	logic [7:0]                    chr_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          out_last_q;

	logic                          have;
	logic                          out_free;
	logic                          emit;
	logic [cle_pkg::NUM_SLOTS-1:0] first_oh;
	logic [cle_pkg::NUM_SLOTS-1:0] mask_after;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// Pick the lowest pending slot and decide whether the next job is loaded.
	always_comb begin
		have       = (mask_q != '0);
		out_free   = !out_valid_q || out_ready;
		emit       = have && out_free;
		first_oh   = mask_q & (~mask_q + 1'b1);
		mask_after = mask_q & ~first_oh;
		q_pop      = q_valid && (!have || (emit && mask_after == '0));
	end

	// Current job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (q_pop) begin
			mask_q <= q_job.mask;
		end else if (emit) begin
			mask_q <= mask_after;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			chr_q <= q_job.chr;
		end
	end

	// Output register: holds a word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cle_pkg::slot_byte(first_oh, chr_q);
			out_last_q <= first_oh[cle_pkg::SLOT_CLOSE];
		end
	end

	// The closing word is always a quote.
	`CLE_ASSERT_IMP(a_last_is_quote, clk, arst_n, out_valid_q && out_last_q,
		out_byte_q == cle_pkg::CH_QUOTE)
	// Every job carries at least one byte.
	`CLE_ASSERT_IMP(a_job_not_empty, clk, arst_n, q_pop, q_job.mask != '0)
	// An idle back part picks up a waiting job at once.
	`CLE_ASSERT_NXT(a_idle_loads, clk, arst_n, q_valid && !have, mask_q != '0)

endmodule

`default_nettype wire

/* sv/c_string_literal_escaper.sv */
// The first word caused by an input word passes the queue write at the accepting edge, the
// job load and the output register before it is valid, when the back part is idle.
// Throughput: one output word per cycle while the sink is ready; an input word causes one
// to eight output words, and input is taken every cycle while the job queue has room, so
// the output port sets the rate.
// Reset: arst_n clears the literal state, the queue and the output; max_line returns to 100.
`timescale 1ns / 1ps
`default_nettype none

module c_string_literal_escaper #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] mode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
	output logic             m_axis_tlast
);

	logic          push;
	cle_pkg::job_t push_job;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	cle_pkg::job_t q_job;

	// Front part: lookahead state and classification.
	cle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_mode     (s_axis_tuser[0]),
		.in_data     (s_axis_tdata),
		.push        (push),
		.push_job    (push_job),
		.q_full      (q_full)
	);

	// Job queue between the two parts.
	cle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_job   (q_job)
	);

	// Back part: byte sequencer and output register.
	cle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

/* bench/tb_c_string_literal_escaper.sv */
// Self-checking testbench for the C string literal escaper, with a scoreboard class and stream drivers.
`timescale 1ns / 1ps

module tb_c_string_literal_escaper;

	// Values of the mode bit carried in s_axis_tuser.
	localparam bit MODE_CHAR  = 1'b0;
	localparam bit MODE_CLOSE = 1'b1;

	// One word of literal text as it should leave the block.
	typedef struct packed {
		bit [7:0] out_byte;
		bit       last;
	} lit_word_t;

	// Tracks the literal state and holds the text still to come out.
	class literal_text_model;
		bit [7:0]  max_line;
		bit        started;
		bit        held_valid;
		bit [7:0]  held_byte;
		bit [7:0]  line_count;
		lit_word_t text_due[$];
		int        errors;
		int        words_in;
		int        words_out;

		function new();
			max_line   = cle_pkg::MAX_LINE_RESET;
			started    = 1'b0;
			held_valid = 1'b0;
			held_byte  = 8'h00;
			line_count = 8'h00;
			errors     = 0;
			words_in   = 0;
			words_out  = 0;
		endfunction

		function void set_max_line(input bit [7:0] v);
			max_line = v;
		endfunction

		function int pending();
			return text_due.size();
		endfunction

		function void put(input bit [7:0] b, input bit last);
			text_due.push_back({b, last});
		endfunction

		// Letter that follows the backslash, or NO_ESCAPE for a plain byte.
		function bit [7:0] escape_of(input bit [7:0] b);
			case (b)
				8'h00:              return cle_pkg::CH_ZERO;
				8'h07:              return "a";
				8'h08:              return "b";
				8'h0C:              return "f";
				cle_pkg::CH_LF:     return cle_pkg::CH_N;
				8'h0D:              return "r";
				8'h09:              return "t";
				8'h0B:              return "v";
				"?":                return "?";
				"'":                return "'";
				cle_pkg::CH_QUOTE:  return cle_pkg::CH_QUOTE;
				cle_pkg::CH_BSLASH: return cle_pkg::CH_BSLASH;
				default:            return cle_pkg::NO_ESCAPE;
			endcase
		endfunction

		// Encodes the held byte now that the following item is known.
		function void emit_held(input bit next_char, input bit [7:0] nxt);
			bit [7:0] esc;
			esc = escape_of(held_byte);
			if (held_byte == cle_pkg::CH_LF && next_char) begin
				put(cle_pkg::CH_BSLASH, 1'b0);
				put(cle_pkg::CH_N, 1'b0);
				put(cle_pkg::CH_QUOTE, 1'b0);
				put(cle_pkg::CH_LF, 1'b0);
				put(cle_pkg::CH_QUOTE, 1'b0);
				line_count = 8'h00;
			end else if (esc != cle_pkg::NO_ESCAPE) begin
				put(cle_pkg::CH_BSLASH, 1'b0);
				put(esc, 1'b0);
				line_count = line_count + 8'd1;
			end else begin
				put(held_byte, 1'b0);
				line_count = line_count + 8'd1;
			end
			// A full line is broken unless a newline comes next anyway.
			if (line_count == max_line && !(next_char && nxt == cle_pkg::CH_LF)) begin
				put(cle_pkg::CH_QUOTE, 1'b0);
				put(cle_pkg::CH_LF, 1'b0);
				put(cle_pkg::CH_QUOTE, 1'b0);
				line_count = 8'h00;
			end
			held_valid = 1'b0;
		endfunction

		// Notes one accepted input word and queues the text it causes.
		function void accept_item(input bit mode, input bit [7:0] data);
			words_in++;
			if (!started) begin
				put(cle_pkg::CH_QUOTE, 1'b0);
				started = 1'b1;
			end
			if (mode == MODE_CLOSE) begin
				if (held_valid)
					emit_held(1'b0, 8'h00);
				put(cle_pkg::CH_QUOTE, 1'b1);
				started    = 1'b0;
				held_valid = 1'b0;
				held_byte  = 8'h00;
				line_count = 8'h00;
			end else begin
				if (held_valid)
					emit_held(1'b1, data);
				held_byte  = data;
				held_valid = 1'b1;
			end
		endfunction

		// Compares one output word with the oldest queued word.
		function void check_word(input bit [7:0] b, input bit last);
			lit_word_t w;
			words_out++;
			if (text_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: out_byte %h last %b", b, last);
				return;
			end
			w = text_due.pop_front();
			if (w.out_byte !== b || w.last !== last) begin
				errors++;
				if (errors <= 10)
					$display("word %0d: expected out_byte %h last %b, got out_byte %h last %b",
						words_out, w.out_byte, w.last, b, last);
			end
		endfunction

		// Anything still queued at the end never came out.
		function void finish_check();
			if (text_due.size() != 0) begin
				errors++;
				$display("%0d words of literal text never arrived", text_due.size());
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] data_byte
	logic [0:0] s_axis_tuser;   // [0] mode
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [7:0] out_byte
	logic       m_axis_tlast;

	literal_text_model text;
	bit        tx_idle;
	int        rx_hold = 0;
	bit [7:0]  mid_line;
	bit [7:0]  escapable [12] = '{8'h00, 8'h07, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B,
		8'h3F, 8'h27, 8'h22, 8'h5C};

	c_string_literal_escaper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Offers one word, after a random gap when tx_idle is set, and waits for it to be taken.
	task automatic put_word(input bit mode, input bit [7:0] data);
		int gap;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
		text.accept_item(mode, data);
	endtask

	// Stops offering words until all queued text has come out.
	task automatic drain_text();
		s_axis_tvalid <= 1'b0;
		while (text.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes the line length register while the block is idle.
	task automatic set_line(input bit [7:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		text.set_max_line(v);
	endtask

	// Text byte biased toward escapes, newlines and zero bytes.
	function automatic bit [7:0] pick_byte(input int lf_pct);
		int r;
		bit [7:0] b;
		r = $urandom_range(0, 99);
		if (r < lf_pct)
			return cle_pkg::CH_LF;
		if (r < lf_pct + 20)
			b = escapable[$urandom_range(0, 11)];
		else if (r < lf_pct + 25)
			b = 8'h00;
		else
			b = 8'($urandom_range(0, 255));
		// Long unbroken lines need text free of newlines.
		if (lf_pct == 0 && b == cle_pkg::CH_LF)
			b = 8'h41;
		return b;
	endfunction

	// Sends len text bytes and then the closing word.
	task automatic send_literal(input int len, input int lf_pct);
		tx_idle = ($urandom_range(0, 3) != 0);
		repeat (len) put_word(MODE_CHAR, pick_byte(lf_pct));
		put_word(MODE_CLOSE, 8'($urandom_range(0, 255)));
	endtask

	// One line length setting with random literals of bounded length.
	task automatic run_phase(input bit [7:0] line, input int items, input int maxlen,
		input int lf_pct);
		int sent;
		int len;
		sent = 0;
		set_line(line);
		while (sent < items) begin
			len = $urandom_range(0, maxlen);
			send_literal(len, lf_pct);
			sent += len + 1;
		end
		drain_text();
	endtask

	// Receiver: random back-pressure, with one long hold when the stimulus sets rx_hold.
	initial begin : rx_proc
		int  gap;
		int  words;
		bit  rx_idle;
		words   = 0;
		rx_idle = 1'b1;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (words % 32 == 0)
				rx_idle = ($urandom_range(0, 2) != 0);
			gap = rx_idle ? $urandom_range(0, 14) : 0;
			if (rx_hold > 0) begin
				gap     = rx_hold;
				rx_hold = 0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			text.check_word(m_axis_tdata, m_axis_tlast);
			words++;
		end
	end

	// Stimulus and final verdict.
	initial begin : main_proc
		text = new();
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_wr_data   <= 8'h00;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tuser  <= MODE_CHAR;
		tx_idle = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two empty literals back to back.
		put_word(MODE_CLOSE, 8'h00);
		put_word(MODE_CLOSE, 8'hFF);
		// Every escaped byte, the newline among them followed by data, then two plain bytes.
		foreach (escapable[i])
			put_word(MODE_CHAR, escapable[i]);
		put_word(MODE_CHAR, 8'hFF);
		put_word(MODE_CHAR, 8'h41);
		put_word(MODE_CLOSE, 8'h00);
		// Newline followed by a zero byte, and a newline as the last byte.
		put_word(MODE_CHAR, cle_pkg::CH_LF);
		put_word(MODE_CHAR, 8'h00);
		put_word(MODE_CHAR, cle_pkg::CH_LF);
		put_word(MODE_CLOSE, 8'h80);
		drain_text();
		// Full line on the last byte still breaks before the close.
		set_line(8'd2);
		put_word(MODE_CHAR, "x");
		put_word(MODE_CHAR, "y");
		put_word(MODE_CLOSE, 8'h00);
		drain_text();

		// Random literals over several line lengths.
		run_phase(8'd1, 40, 6, 15);
		run_phase(8'd2, 30, 8, 15);
		mid_line = 8'($urandom_range(3, 20));
		rx_hold  = 300;
		run_phase(mid_line, 100, 30, 10);
		// A zero line length wraps the count, so the break comes after 256 characters.
		set_line(8'd0);
		send_literal(260, 0);
		drain_text();
		repeat (20) @(posedge clk);

		text.finish_check();
		$display("Sent %0d input words and checked %0d words of literal text,", text.words_in,
			text.words_out);
		$display("with line lengths 100, 2, 1, %0d and 0 under random back-pressure.",
			mid_line);
		if (text.errors == 0)
			$display("tb_c_string_literal_escaper: clean");
		else
			$display("tb_c_string_literal_escaper: errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#10_000_000;
		$display("tb_c_string_literal_escaper: errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/cle_pkg.sv
sv/cle_queue.sv
sv/cle_front.sv
sv/cle_back.sv
sv/c_string_literal_escaper.sv
bench/tb_c_string_literal_escaper.sv
